[rtl/assert_macros.svh]
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define SAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/saa_pkg.sv]
// types and codes for the stack arena allocator
// no dependencies
package saa_pkg;
  localparam int OFFSET_BITS = 24;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_POP   = 2'd2;
  localparam logic [1:0] ACT_RESET = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ARENA  = 2'd1;
  localparam logic [1:0] ST_STACK  = 2'd2;
  localparam logic [1:0] ST_MARKER = 2'd3;

  localparam logic [1:0] REG_ARENA_SIZE = 2'd0;
  localparam logic [1:0] REG_BASE_ADDR  = 2'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] request_size;
    logic [3:0]  align_log2;
    logic [23:0] rewind_marker;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_address;
    logic [23:0] current_offset;
    logic [23:0] peak_used;
    logic [31:0] alloc_count;
    logic [31:0] failure_count;
    logic [39:0] bytes_requested;
    logic [39:0] bytes_consumed;
    logic [39:0] padding_waste;
  } rsp_t;
endpackage

[rtl/saa_if.sv]
// valid/ready channel interfaces for requests and results
// depends on saa_pkg
interface saa_req_if import saa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [23:0] request_size;
  logic [3:0]  align_log2;
  logic [23:0] rewind_marker;
  modport source (output valid, action, request_size, align_log2, rewind_marker, input ready);
  modport sink (input valid, action, request_size, align_log2, rewind_marker, output ready);
endinterface

interface saa_rsp_if import saa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_address;
  logic [23:0] current_offset;
  logic [23:0] peak_used;
  logic [31:0] alloc_count;
  logic [31:0] failure_count;
  logic [39:0] bytes_requested;
  logic [39:0] bytes_consumed;
  logic [39:0] padding_waste;
  modport source (output valid, status, block_address, current_offset, peak_used, alloc_count,
    failure_count, bytes_requested, bytes_consumed, padding_waste, input ready);
  modport sink (input valid, status, block_address, current_offset, peak_used, alloc_count,
    failure_count, bytes_requested, bytes_consumed, padding_waste, output ready);
endinterface

[rtl/saa_front.sv]
// request front end: two-entry word queue between the port and the engine
// depends on saa_pkg
module saa_front import saa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_word,
  output logic q_valid,
  input  logic q_take,
  output req_t q_word
);
  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_word   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_take && q_valid) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_take && q_valid);
    end
  end
endmodule

[rtl/saa_back.sv]
// allocation engine: arithmetic, stacks, counters and the result register
// depends on saa_pkg
module saa_back import saa_pkg::*; #(
  parameter int ROLLBACK_DEPTH   = 64,
  parameter int CHECKPOINT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [23:0] arena_size,
  input  logic [31:0] base_address,
  input  logic        q_valid,
  output logic        q_take,
  input  req_t        q_word,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_word
);
  localparam int RB_AW = $clog2(ROLLBACK_DEPTH);
  localparam int CP_AW = $clog2(CHECKPOINT_DEPTH);
  localparam int RB_CW = $clog2(ROLLBACK_DEPTH + 1);
  localparam int CP_CW = $clog2(CHECKPOINT_DEPTH + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_CALC = 3'd1, S_RB = 3'd2, S_CP = 3'd3,
    S_DONE = 3'd4;
  localparam logic [32:0] OFFSET_MAX = (33'd1 << OFFSET_BITS) - 33'd1;

  logic [2:0]  state;
  req_t        cur;
  logic [23:0] offset, peak;
  logic [RB_CW-1:0] rb_cnt;
  logic [CP_CW-1:0] cp_cnt;
  logic [31:0] grants, fails;
  logic [39:0] req_sum, con_sum, pad_sum;
  logic [23:0] rb_mem [ROLLBACK_DEPTH];
  logic [23:0] cp_mem [CHECKPOINT_DEPTH];
  logic [23:0] rb_rd, cp_rd;
  logic        rd_ok;
  logic [31:0] addr, amask, pad;
  logic [33:0] need;
  logic [32:0] limit;
  logic [1:0]  status;
  logic [31:0] block;

  assign limit = ({9'd0, arena_size} < OFFSET_MAX) ? {9'd0, arena_size} : OFFSET_MAX;
  assign addr  = base_address + {8'd0, offset};
  assign amask = (32'd1 << cur.align_log2) - 32'd1;
  assign pad   = (32'd0 - addr) & amask;
  assign need  = {10'd0, offset} + {2'd0, pad} + {10'd0, cur.request_size};
  assign q_take = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (state == S_RB && rb_cnt != '0) rb_rd <= rb_mem[RB_AW'(rb_cnt - 1'b1)];
    if (state == S_CP && cp_cnt != '0) cp_rd <= cp_mem[CP_AW'(cp_cnt - 1'b1)];
    if (state == S_CALC && cur.action == ACT_ALLOC && need <= {1'b0, limit}
        && rb_cnt < RB_CW'(ROLLBACK_DEPTH))
      rb_mem[RB_AW'(rb_cnt)] <= offset;
    if (state == S_CALC && cur.action == ACT_PUSH && cp_cnt < CP_CW'(CHECKPOINT_DEPTH))
      cp_mem[CP_AW'(cp_cnt)] <= offset;
  end

  always_ff @(posedge clk) begin
    if (q_take && q_valid) cur <= q_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      offset <= '0; peak <= '0; rb_cnt <= '0; cp_cnt <= '0;
      grants <= '0; fails <= '0; req_sum <= '0; con_sum <= '0; pad_sum <= '0;
      rd_ok <= 1'b0;
      status <= ST_OK; block <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_take && q_valid) state <= S_CALC;
        S_CALC: begin
          status <= ST_OK;
          block <= '0;
          rd_ok <= 1'b0;
          state <= S_DONE;
          case (cur.action)
            ACT_ALLOC: begin
              if (need > {1'b0, limit}) begin
                status <= ST_ARENA; fails <= fails + 32'd1;
              end else if (rb_cnt >= RB_CW'(ROLLBACK_DEPTH)) begin
                status <= ST_STACK; fails <= fails + 32'd1;
              end else begin
                rb_cnt <= rb_cnt + 1'b1;
                offset <= need[23:0];
                if (need[23:0] > peak) peak <= need[23:0];
                grants <= grants + 32'd1;
                req_sum <= req_sum + {16'd0, cur.request_size};
                con_sum <= con_sum + {16'd0, cur.request_size} + {8'd0, pad};
                pad_sum <= pad_sum + {8'd0, pad};
                block <= addr + pad;
              end
            end
            ACT_PUSH: begin
              if (cp_cnt >= CP_CW'(CHECKPOINT_DEPTH)) status <= ST_STACK;
              else cp_cnt <= cp_cnt + 1'b1;
            end
            ACT_POP: begin
              if (cur.rewind_marker > offset) status <= ST_MARKER;
              else state <= S_RB;
            end
            default: begin
              offset <= '0; peak <= '0; rb_cnt <= '0; cp_cnt <= '0;
              grants <= '0; fails <= '0; req_sum <= '0; con_sum <= '0; pad_sum <= '0;
            end
          endcase
        end
        S_RB: begin
          // rd_ok marks rb_rd valid for the current top
          if (!rd_ok) begin
            if (rb_cnt == '0) begin state <= S_CP; end
            else rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (rb_rd >= cur.rewind_marker) rb_cnt <= rb_cnt - 1'b1;
            else state <= S_CP;
          end
        end
        S_CP: begin
          if (!rd_ok) begin
            if (cp_cnt == '0) begin offset <= cur.rewind_marker; state <= S_DONE; end
            else rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (cp_rd >= cur.rewind_marker) cp_cnt <= cp_cnt - 1'b1;
            else begin offset <= cur.rewind_marker; state <= S_DONE; end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_word = '{status: status, block_address: block, current_offset: offset,
    peak_used: peak, alloc_count: grants, failure_count: fails,
    bytes_requested: req_sum, bytes_consumed: con_sum, padding_waste: pad_sum};
endmodule

[rtl/stack_arena_allocator.sv]
// channel    dir  fields
// req        in   action request_size align_log2 rewind_marker
// rsp        out  status block_address offsets counters sums
// apb        in   arena_size @0x0, base_address @0x4
// allocate, push, reject and reset pass from accept through S_CALC and S_DONE to the result
// pop drops rollback, then checkpoint entries at or above the marker (S_RB, S_CP) and sets the offset to it
// a request is queued (two words) while the engine is busy; one word is worked at a time
// a result waits in the output register; the engine holds until it is taken
// rst is synchronous; the stacks need no clearing after reset
// depends on saa_pkg, saa_if, saa_front, saa_back, assert_macros.svh
`include "assert_macros.svh"
module stack_arena_allocator import saa_pkg::*; #(
  parameter int ROLLBACK_DEPTH   = 64,
  parameter int CHECKPOINT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  saa_req_if.sink     req,
  saa_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [23:0] arena_size;
  logic [31:0] base_address;
  logic        q_valid, q_take;
  req_t        q_word, in_word;
  rsp_t        out_word;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size <= 24'd65536;
      base_address <= '0;
    end else if (wr) begin
      if (paddr[2] == REG_BASE_ADDR[0]) base_address <= pwdata;
      else arena_size <= pwdata[23:0];
    end
  end
  always_comb begin
    case (paddr[2])
      REG_ARENA_SIZE[0]: prdata = {8'd0, arena_size};
      default:           prdata = base_address;
    endcase
  end

  assign in_word = '{action: req.action, request_size: req.request_size,
    align_log2: req.align_log2, rewind_marker: req.rewind_marker};

  saa_front u_front (.clk, .rst, .in_valid(req.valid), .in_ready(req.ready), .in_word,
    .q_valid, .q_take, .q_word);

  saa_back #(.ROLLBACK_DEPTH(ROLLBACK_DEPTH), .CHECKPOINT_DEPTH(CHECKPOINT_DEPTH))
    u_back (.clk, .rst, .arena_size, .base_address,
    .q_valid, .q_take, .q_word, .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word);

  assign rsp.status = out_word.status;
  assign rsp.block_address = out_word.block_address;
  assign rsp.current_offset = out_word.current_offset;
  assign rsp.peak_used = out_word.peak_used;
  assign rsp.alloc_count = out_word.alloc_count;
  assign rsp.failure_count = out_word.failure_count;
  assign rsp.bytes_requested = out_word.bytes_requested;
  assign rsp.bytes_consumed = out_word.bytes_consumed;
  assign rsp.padding_waste = out_word.padding_waste;

  `SAA_ASSERT(a_fail_no_block, rsp.valid && rsp.status != ST_OK |-> rsp.block_address == 32'd0, "failed word carries an address")
  `SAA_ASSERT(a_peak_ge_off, rsp.valid |-> rsp.peak_used >= rsp.current_offset, "peak below offset")
  `SAA_ASSERT_RST(a_rst_idle, rst |=> !rsp.valid, "result valid after reset")
endmodule
